// ----- sv/blemidi_pkg.sv -----
// Package for the BLE-MIDI packet decoder.
// Holds the payload structs, parser phase encoding, status constants and a helper.
// No dependencies.
package blemidi_pkg;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       first_of_packet;
    logic       last_of_packet;
  } in_item_t;

  typedef struct packed {
    logic [7:0] message_status;
    logic [6:0] first_data;
    logic [6:0] second_data;
    logic [1:0] data_len;
  } out_item_t;

  // Result of one parse step, handed to the output register.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } parse_res_t;

  typedef enum logic [5:0] {
    PH_HEADER  = 6'b000001,
    PH_IDLE    = 6'b000010,
    PH_HELD    = 6'b000100,
    PH_NEED_D1 = 6'b001000,
    PH_NEED_D2 = 6'b010000,
    PH_ABANDON = 6'b100000
  } phase_t;

  localparam logic [7:0] SYS_BASE      = 8'hF0;
  localparam logic [7:0] RT_BASE       = 8'hF8;
  localparam logic [3:0] PROG_CHANGE   = 4'hC;
  localparam logic [3:0] CHAN_PRESSURE = 4'hD;
  localparam logic [1:0] ONE_DATA      = 2'd1;
  localparam logic [1:0] TWO_DATA      = 2'd2;

  // Number of data bytes that follow a channel status.
  function automatic logic [1:0] data_bytes_for(input logic [7:0] status);
    logic [3:0] hi;
    hi = status[7:4];
    if (hi == PROG_CHANGE || hi == CHAN_PRESSURE) begin
      data_bytes_for = ONE_DATA;
    end else begin
      data_bytes_for = TWO_DATA;
    end
  endfunction

endpackage

// ----- sv/ble_midi_packet_decoder_core.sv -----
// Top level of the BLE-MIDI packet decoder.
// Instantiates blemidi_in_stage, blemidi_parser and blemidi_out_stage; uses blemidi_pkg.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready   | in_item_t: byte, first, last flags
//   out_    | output    | out_valid / out_ready | out_item_t: status, data, count
//
// One byte per cycle is sustained while the output is not stalled; a byte passes
// through the input register and the combinational parser into the result register.
// A byte that completes a channel message yields one result; others yield none.
// Reset is synchronous on rst_n and returns the parser to waiting for a header.
// A stalled output holds the parser; the input register still takes one byte.
module ble_midi_packet_decoder_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  blemidi_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output blemidi_pkg::out_item_t out_data
);

  logic                    stage_valid;
  blemidi_pkg::in_item_t   stage_data;
  logic                    room;
  logic                    advance;
  blemidi_pkg::parse_res_t res;

  assign advance = stage_valid && room;

  blemidi_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_data  (stage_data)
  );

  blemidi_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (stage_data),
    .res   (res)
  );

  blemidi_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- sv/blemidi_in_stage.sv -----
// Input register of the BLE-MIDI packet decoder.
// Captures one packet byte per transaction; uses blemidi_pkg.
module blemidi_in_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  blemidi_pkg::in_item_t in_data,
  input  logic                  advance,
  output logic                  stage_valid,
  output blemidi_pkg::in_item_t stage_data
);

  logic                  valid_r;
  logic                  valid_nxt;
  blemidi_pkg::in_item_t data_r;

  assign in_ready    = !valid_r || advance;
  assign stage_valid = valid_r;
  assign stage_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

// ----- sv/blemidi_parser.sv -----
// Parser state machine of the BLE-MIDI packet decoder.
// Holds running status and the partial message; uses blemidi_pkg.
module blemidi_parser (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  blemidi_pkg::in_item_t   item,
  output blemidi_pkg::parse_res_t res
);

  blemidi_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] rs_r, rs_nxt;
  logic [7:0] pend_r, pend_nxt;
  logic [7:0] hs_r, hs_nxt;
  logic [6:0] d1_r, d1_nxt;

  logic [7:0] b;
  logic       first;
  logic       last;
  logic       stat_en;
  logic       start_en;
  logic [7:0] start_st;

  assign b     = item.packet_byte;
  assign first = item.first_of_packet;
  assign last  = item.last_of_packet;

  always_comb begin
    phase_nxt = phase_r;
    rs_nxt    = rs_r;
    pend_nxt  = pend_r;
    hs_nxt    = hs_r;
    d1_nxt    = d1_r;
    res       = '0;
    stat_en   = 1'b0;
    start_en  = 1'b0;
    start_st  = rs_r;

    if (first) begin
      phase_nxt = last ? blemidi_pkg::PH_HEADER : blemidi_pkg::PH_IDLE;
    end else begin
      unique case (phase_r)
        blemidi_pkg::PH_IDLE: begin
          if (b[7]) begin
            // A lone high-bit byte at the end of a packet can only be a status.
            if (last) begin
              stat_en = 1'b1;
            end else begin
              pend_nxt  = b;
              phase_nxt = blemidi_pkg::PH_HELD;
            end
          end else if (rs_r[7]) begin
            start_en = 1'b1;
          end else begin
            phase_nxt = blemidi_pkg::PH_ABANDON;
          end
        end
        blemidi_pkg::PH_HELD: begin
          if (b[7]) begin
            stat_en = 1'b1;
          end else if (rs_r[7]) begin
            start_en = 1'b1;
          end else if (pend_r < blemidi_pkg::SYS_BASE) begin
            // The held byte was a channel status after all.
            start_en = 1'b1;
            start_st = pend_r;
            rs_nxt   = pend_r;
          end else begin
            phase_nxt = blemidi_pkg::PH_ABANDON;
          end
        end
        blemidi_pkg::PH_NEED_D1: begin
          if (b[7]) begin
            phase_nxt = blemidi_pkg::PH_ABANDON;
          end else begin
            start_en = 1'b1;
            start_st = hs_r;
          end
        end
        blemidi_pkg::PH_NEED_D2: begin
          if (b[7]) begin
            phase_nxt = blemidi_pkg::PH_ABANDON;
          end else begin
            res.valid               = 1'b1;
            res.item.message_status = hs_r;
            res.item.first_data     = d1_r;
            res.item.second_data    = b[6:0];
            res.item.data_len       = blemidi_pkg::TWO_DATA;
            phase_nxt               = blemidi_pkg::PH_IDLE;
          end
        end
        blemidi_pkg::PH_HEADER, blemidi_pkg::PH_ABANDON: begin
        end
        default: begin
          phase_nxt = blemidi_pkg::PH_HEADER;
        end
      endcase

      if (stat_en) begin
        if (b < blemidi_pkg::SYS_BASE) begin
          rs_nxt    = b;
          hs_nxt    = b;
          phase_nxt = blemidi_pkg::PH_NEED_D1;
        end else if (b >= blemidi_pkg::RT_BASE) begin
          phase_nxt = blemidi_pkg::PH_IDLE;
        end else begin
          phase_nxt = blemidi_pkg::PH_ABANDON;
        end
      end

      if (start_en) begin
        hs_nxt = start_st;
        if (blemidi_pkg::data_bytes_for(start_st) == blemidi_pkg::ONE_DATA) begin
          res.valid               = 1'b1;
          res.item.message_status = start_st;
          res.item.first_data     = b[6:0];
          res.item.second_data    = 7'd0;
          res.item.data_len       = blemidi_pkg::ONE_DATA;
          phase_nxt               = blemidi_pkg::PH_IDLE;
        end else begin
          d1_nxt    = b[6:0];
          phase_nxt = blemidi_pkg::PH_NEED_D2;
        end
      end

      // The end of a packet drops any unfinished message and clears an abandon.
      if (last) begin
        phase_nxt = blemidi_pkg::PH_HEADER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= blemidi_pkg::PH_HEADER;
      rs_r    <= 8'h00;
    end else if (step) begin
      phase_r <= phase_nxt;
      rs_r    <= rs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pend_r <= pend_nxt;
      hs_r   <= hs_nxt;
      d1_r   <= d1_nxt;
    end
  end

endmodule

// ----- sv/blemidi_out_stage.sv -----
// Result register of the BLE-MIDI packet decoder.
// Holds one decoded message until the consumer takes it; uses blemidi_pkg.
module blemidi_out_stage (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  blemidi_pkg::parse_res_t res,
  output logic                    room,
  output logic                    out_valid,
  input  logic                    out_ready,
  output blemidi_pkg::out_item_t  out_data
);

  logic                   valid_r;
  logic                   valid_nxt;
  blemidi_pkg::out_item_t data_r;
  logic                   take;

  assign take      = load && res.valid;
  assign room      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= res.item;
    end
  end

endmodule

// ----- sv/blemidi_checker.sv -----
// Port-level checks for the BLE-MIDI packet decoder.
// Bound to ble_midi_packet_decoder_core; uses blemidi_pkg.
module blemidi_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input blemidi_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_chan_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.message_status[7] && out_data.message_status[7:4] != 4'hF)
    else $error("result status is not a channel status");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.data_len ==
      blemidi_pkg::data_bytes_for(out_data.message_status))
    else $error("data count does not match status");

  a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.data_len == blemidi_pkg::ONE_DATA |->
      out_data.second_data == 7'd0)
    else $error("second data byte not zero for a one-byte message");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ble_midi_packet_decoder_core blemidi_checker u_blemidi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- dv/tb_ble_midi_packet_decoder_core.sv -----
`timescale 1ns / 100ps
// Testbench for ble_midi_packet_decoder_core: directed and random BLE-MIDI packets.
// It predicts the decoded channel messages and checks every output transaction.
// Depends on blemidi_pkg and the RTL of the decoder.
module tb_ble_midi_packet_decoder_core;

  localparam int IDLE_LIMIT = 2000;
  localparam int BYTE_TARGET = 1550;

  // Decoded-message scoreboard with its own copy of the parser state.
  class midi_scoreboard;
    logic [7:0]             run_status;
    blemidi_pkg::phase_t    phase;
    logic [7:0]             held_byte;
    logic [7:0]             msg_status;
    logic [6:0]             msg_first;
    bit                     dropped;
    blemidi_pkg::out_item_t due_msgs[$];
    int                     fail_count;
    int                     msg_count;

    function new();
      run_status = 8'h00;
      phase      = blemidi_pkg::PH_HEADER;
      held_byte  = 8'h00;
      msg_status = 8'h00;
      msg_first  = 7'h00;
      dropped    = 1'b0;
      fail_count = 0;
      msg_count  = 0;
    endfunction

    function void drop_packet();
      dropped = 1'b1;
      phase   = blemidi_pkg::PH_IDLE;
    endfunction

    function void finish_msg(logic [6:0] d1, logic [6:0] d2, logic [1:0] cnt);
      blemidi_pkg::out_item_t m;
      m.message_status = msg_status;
      m.first_data     = d1;
      m.second_data    = d2;
      m.data_len       = cnt;
      due_msgs.insert(due_msgs.size(), m);
      phase = blemidi_pkg::PH_IDLE;
    endfunction

    function void take_status(logic [7:0] s);
      if (s < blemidi_pkg::SYS_BASE) run_status = s;
      if (s >= blemidi_pkg::RT_BASE) begin
        phase = blemidi_pkg::PH_IDLE;
      end else if (s >= blemidi_pkg::SYS_BASE) begin
        drop_packet();
      end else begin
        msg_status = s;
        phase      = blemidi_pkg::PH_NEED_D1;
      end
    endfunction

    function void take_data(logic [7:0] d);
      if (d[7]) begin
        drop_packet();
      end else if (phase == blemidi_pkg::PH_NEED_D1) begin
        if (msg_status[7:4] == blemidi_pkg::PROG_CHANGE ||
            msg_status[7:4] == blemidi_pkg::CHAN_PRESSURE) begin
          finish_msg(d[6:0], 7'h00, blemidi_pkg::ONE_DATA);
        end else begin
          msg_first = d[6:0];
          phase     = blemidi_pkg::PH_NEED_D2;
        end
      end else begin
        finish_msg(msg_first, d[6:0], blemidi_pkg::TWO_DATA);
      end
    endfunction

    function void start_running(logic [7:0] d);
      msg_status = run_status;
      phase      = blemidi_pkg::PH_NEED_D1;
      take_data(d);
    endfunction

    function void at_boundary(logic [7:0] b, bit last);
      if (b[7]) begin
        if (last) begin
          take_status(b);
        end else begin
          held_byte = b;
          phase     = blemidi_pkg::PH_HELD;
        end
      end else if (!run_status[7]) begin
        drop_packet();
      end else begin
        start_running(b);
      end
    endfunction

    // The held high-bit byte is a timestamp unless a data byte follows it
    // while no running status exists.
    function void resolve_held(logic [7:0] b, bit last);
      if (b[7]) begin
        take_status(b);
      end else if (run_status[7]) begin
        start_running(b);
      end else begin
        take_status(held_byte);
        if (!dropped) begin
          if (phase == blemidi_pkg::PH_IDLE) at_boundary(b, last);
          else take_data(b);
        end
      end
    endfunction

    function void note_input(blemidi_pkg::in_item_t it);
      if (it.first_of_packet) begin
        dropped = 1'b0;
        phase   = it.last_of_packet ? blemidi_pkg::PH_HEADER : blemidi_pkg::PH_IDLE;
        return;
      end
      if (phase == blemidi_pkg::PH_HEADER) return;
      if (!dropped) begin
        case (phase)
          blemidi_pkg::PH_IDLE: at_boundary(it.packet_byte, it.last_of_packet);
          blemidi_pkg::PH_HELD: resolve_held(it.packet_byte, it.last_of_packet);
          default: take_data(it.packet_byte);
        endcase
      end
      if (it.last_of_packet) begin
        phase   = blemidi_pkg::PH_HEADER;
        dropped = 1'b0;
      end
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(blemidi_pkg::out_item_t got);
      blemidi_pkg::out_item_t want;
      if (due_msgs.size() == 0) begin
        $error("unexpected message: status %0h", got.message_status);
        fail_count++;
        return;
      end
      want = due_msgs[0];
      due_msgs.delete(0);
      msg_count++;
      compare_field("message_status", want.message_status, got.message_status);
      compare_field("first_data", want.first_data, got.first_data);
      compare_field("second_data", want.second_data, got.second_data);
      compare_field("data_len", want.data_len, got.data_len);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  blemidi_pkg::in_item_t  in_data;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  blemidi_pkg::out_item_t out_data;

  midi_scoreboard sb;
  bit         no_gaps = 1'b0;
  int         bytes_sent = 0;
  int         packets_sent = 0;
  int         idle_cycles = 0;
  int         ready_left = 0;
  logic [7:0] gen_status = 8'h00;
  logic [9:0] corner_seq[$];

  ble_midi_packet_decoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [6:0] rand7();
    return 7'($urandom_range(0, 127));
  endfunction

  always @(negedge clk) begin
    int gap;
    if (ready_left > 0) begin
      ready_left--;
    end else if (out_ready) begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ready  <= 1'b0;
        ready_left = gap - 1;
      end else begin
        ready_left = $urandom_range(0, 7);
      end
    end else begin
      out_ready  <= 1'b1;
      ready_left = $urandom_range(0, 15);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Entered and left at a falling edge.
  task automatic send_byte(logic [7:0] b, bit first, bit last);
    blemidi_pkg::in_item_t it;
    int gap;
    it.packet_byte     = b;
    it.first_of_packet = first;
    it.last_of_packet  = last;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.due_msgs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Mostly well-formed packets: timestamped statuses, running-status data and
  // realtime bytes, with occasional corruption, truncation or a missing end.
  task automatic send_random_packet();
    logic [7:0] pkt[$];
    logic [7:0] st;
    int n_msgs, kind, idx;
    bit mark_last;
    pkt.insert(pkt.size(), {1'b1, rand7()});
    n_msgs = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
    for (int m = 0; m < n_msgs; m++) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        pkt.insert(pkt.size(), {1'b1, rand7()});
        pkt.insert(pkt.size(), {5'b11111, 3'($urandom_range(0, 7))});
      end else begin
        if (kind < 35 && gen_status[7]) begin
          st = gen_status;
          if ($urandom_range(0, 1) == 0) pkt.insert(pkt.size(), {1'b1, rand7()});
        end else begin
          st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom_range(0, 15))};
          if ($urandom_range(0, 19) != 0) pkt.insert(pkt.size(), {1'b1, rand7()});
          pkt.insert(pkt.size(), st);
          gen_status = st;
        end
        pkt.insert(pkt.size(), {1'b0, rand7()});
        if (st[7:4] != blemidi_pkg::PROG_CHANGE &&
            st[7:4] != blemidi_pkg::CHAN_PRESSURE) begin
          pkt.insert(pkt.size(), {1'b0, rand7()});
        end
      end
    end
    if ($urandom_range(0, 4) == 0 && pkt.size() > 1) begin
      idx = $urandom_range(1, pkt.size() - 1);
      case ($urandom_range(0, 3))
        0: pkt[idx] = 8'($urandom_range(0, 255));
        1: while (pkt.size() > idx + 1) pkt.delete(pkt.size() - 1);
        2: pkt.insert(idx, {5'b11110, 3'($urandom_range(0, 7))});
        default: pkt.insert(idx, {1'b0, rand7()});
      endcase
    end
    mark_last = ($urandom_range(0, 19) != 0);
    if ($urandom_range(0, 24) == 0) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    for (int i = 0; i < pkt.size(); i++) begin
      send_byte(pkt[i], i == 0, mark_last && (i == pkt.size() - 1));
    end
    packets_sent++;
  endtask

  initial begin
    bit paused;
    paused   = 1'b0;
    sb       = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    // Each entry is {byte, first_of_packet, last_of_packet}.
    corner_seq = '{
      // A stray byte before any header, then a header-only packet.
      {8'h55, 2'b00}, {8'h80, 2'b11},
      // Data with no running status abandons the packet.
      {8'h80, 2'b10}, {8'h00, 2'b00}, {8'h7F, 2'b01},
      // Status without timestamp while no running status, then running data.
      {8'hFF, 2'b10}, {8'h9F, 2'b00}, {8'h40, 2'b00}, {8'h7F, 2'b00},
      {8'h12, 2'b00}, {8'h00, 2'b00},
      // Timestamp then a one-data status.
      {8'hFF, 2'b00}, {8'hC5, 2'b00}, {8'h22, 2'b00},
      // A system common status abandons the rest of the packet.
      {8'h80, 2'b00}, {8'hF2, 2'b00}, {8'h01, 2'b01},
      // A high-bit byte where data is due.
      {8'h80, 2'b10}, {8'h80, 2'b00}, {8'hD3, 2'b00}, {8'hA0, 2'b00}, {8'h80, 2'b01},
      // Truncated message at the end of a packet.
      {8'h80, 2'b10}, {8'h81, 2'b00}, {8'hE0, 2'b00}, {8'h01, 2'b01},
      // A lone trailing status still sets the running status.
      {8'h80, 2'b10}, {8'hB0, 2'b01},
      // A header arriving mid-packet, flagged as last too.
      {8'h80, 2'b10}, {8'h05, 2'b00}, {8'h80, 2'b11},
      // Realtime byte after a timestamp, then running-status data.
      {8'h80, 2'b10}, {8'h80, 2'b00}, {8'hF8, 2'b00}, {8'h06, 2'b00}, {8'h07, 2'b01}
    };
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (corner_seq[i]) begin
      send_byte(corner_seq[i][9:2], corner_seq[i][1], corner_seq[i][0]);
    end
    gen_status = 8'hB0;
    while (bytes_sent < BYTE_TARGET) begin
      no_gaps = ($urandom_range(0, 9) == 0);
      send_random_packet();
      if (!paused && bytes_sent > BYTE_TARGET / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
    no_gaps = 1'b0;
    wait_drained();
    $display("tb: %0d bytes in %0d random packets plus corner cases, %0d messages checked",
             bytes_sent, packets_sent, sb.msg_count);
    $display("tb: covered errors, truncation, realtime, running status and mid-packet headers");
    if (sb.fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/blemidi_pkg.sv
sv/blemidi_in_stage.sv
sv/blemidi_parser.sv
sv/blemidi_out_stage.sv
sv/ble_midi_packet_decoder_core.sv
sv/blemidi_checker.sv
dv/tb_ble_midi_packet_decoder_core.sv
